>>> hw/rtl/msf_pkg.sv
// Shared types and constants of the multi-source position fuser.
// Holds field widths, status and register codes, and the command and status
// structs between the controller and the datapath. No dependencies.
package msf_pkg;

    localparam int DEF_ROBOT_COUNT  = 8;
    localparam int DEF_SOURCE_COUNT = 4;
    localparam int DEF_GRID_PITCH   = 16;

    localparam int INDEX_W     = 8;
    localparam int COORD_W     = 12;
    localparam int ROOM_W      = 13;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [ROOM_W-1:0] ROOM_RESET = 13'd1024;

    localparam logic [CFG_ADDR_W-1:0] REG_ROOM_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROOM_HEIGHT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_WAIT   = 2'd0,
        ST_FUSED  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_MEAN_X = 2'd0,
        OP_MEAN_Y = 2'd1,
        OP_Q_X    = 2'd2,
        OP_Q_Y    = 2'd3
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    lookup;
        logic    check;
        logic    sum_run;
        logic    div_start;
        div_op_t div_op;
        logic    scale;
        logic    emit;
        status_t emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bad_index;
        logic row_full;
        logic sum_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/multi_source_position_fuser_core.sv
// Multi-source position fuser, top level.
// Position requests (robot, source, x, y) come in on the s_ channel. Each one
// gives exactly one result on the m_ channel: rejected (bad robot or source
// index), stored and waiting, or fused (grid-snapped, clamped mean of the
// robot's latest report from every source, after which its marks are cleared).
// Room width and height are written through cfg_we/cfg_addr/cfg_wdata; the user
// writes them only while the block is idle, which the block itself does not enforce.
// One request at a time: s_tready is high only while no request is in work.
// A rejected request goes from the lookup straight to its result, a stored one
// after the row check; a fused one then walks the robot's row through the report
// memory and runs four divisions by constants through reciprocal multiply, then
// the grid scaling.
// s_tready returns with m_tvalid, so a new request is taken only once the result
// of the last one is in the output register.
// The result sits in an output register; a new request is taken while it
// waits, and work stalls only when the next result finds it still full.
// Reset clears the filled marks through per-robot row valid bits, sets both
// room sizes to 1024 and drops m_tvalid; it needs no clearing pass.
// Depends on msf_pkg, msf_ctrl and msf_datapath.
module multi_source_position_fuser_core #(
    parameter int ROBOT_COUNT  = msf_pkg::DEF_ROBOT_COUNT,
    parameter int SOURCE_COUNT = msf_pkg::DEF_SOURCE_COUNT,
    parameter int GRID_PITCH   = msf_pkg::DEF_GRID_PITCH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // robot_index[7:0], source_index[15:8], pos_x[27:16], pos_y[39:28]
    input  logic [msf_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_robot[7:0], fused_x[19:8], fused_y[31:20]
    output logic [msf_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [msf_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [msf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [msf_pkg::ROOM_W-1:0]      cfg_wdata
);

    import msf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    msf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    msf_datapath #(
        .ROBOT_COUNT  (ROBOT_COUNT),
        .SOURCE_COUNT (SOURCE_COUNT),
        .GRID_PITCH   (GRID_PITCH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> hw/rtl/msf_div.sv
// Division by a build-time constant through reciprocal multiplication.
// The quotient and done are registered, valid in the cycle after start; used by the
// fuser datapath for the mean and the grid rounding. No dependencies.
module msf_div #(
    parameter int DIV_W   = 16,
    parameter int DIVISOR = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    // floor(n * ceil(2^F / D) / 2^F) equals floor(n / D) for every n below 2^DIV_W
    // when F = DIV_W + clog2(D)
    localparam int SHIFT  = $clog2(DIVISOR);
    localparam int FRAC_W = DIV_W + SHIFT;
    localparam int M_W    = FRAC_W + 1;
    localparam int PROD_W = DIV_W + M_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << FRAC_W) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

    logic [PROD_W-1:0] product;
    logic [DIV_W-1:0]  quot_reg;
    logic              done_reg;

    assign product = PROD_W'(dividend) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= product[FRAC_W +: DIV_W];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> hw/rtl/msf_ctrl.sv
// Controller of the fuser: sequences lookup, sum, divisions and result.
// Depends on msf_pkg for the command and status structs.
module msf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  msf_pkg::dp_status_t st,
    output msf_pkg::ctrl_cmd_t  cmd
);

    import msf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t  state_reg;
    div_op_t op_reg;
    status_t status_reg;

    always_comb begin
        cmd             = '0;
        cmd.div_op      = op_reg;
        cmd.emit_status = status_reg;
        cmd.capture     = (state_reg == S_IDLE) && s_tvalid;
        cmd.lookup      = (state_reg == S_LOOKUP) && !st.bad_index;
        cmd.check       = (state_reg == S_CHECK);
        cmd.sum_run     = (state_reg == S_SUM);
        cmd.div_start   = (state_reg == S_DIV_GO);
        cmd.scale       = (state_reg == S_SCALE);
        cmd.emit        = (state_reg == S_EMIT) && st.out_free;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_MEAN_X;
            status_reg <= ST_WAIT;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) state_reg <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    if (st.bad_index) begin
                        status_reg <= ST_REJECT;
                        state_reg  <= S_EMIT;
                    end else begin
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (st.row_full) begin
                        state_reg <= S_SUM;
                    end else begin
                        status_reg <= ST_WAIT;
                        state_reg  <= S_EMIT;
                    end
                end
                S_SUM: begin
                    if (st.sum_done) begin
                        op_reg    <= OP_MEAN_X;
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (st.div_done) begin
                        case (op_reg)
                            OP_MEAN_X: begin
                                op_reg    <= OP_MEAN_Y;
                                state_reg <= S_DIV_GO;
                            end
                            OP_MEAN_Y: begin
                                op_reg    <= OP_Q_X;
                                state_reg <= S_DIV_GO;
                            end
                            OP_Q_X: begin
                                op_reg    <= OP_Q_Y;
                                state_reg <= S_DIV_GO;
                            end
                            default: begin
                                state_reg <= S_SCALE;
                            end
                        endcase
                    end
                end
                S_SCALE: begin
                    status_reg <= ST_FUSED;
                    state_reg  <= S_EMIT;
                end
                S_EMIT: begin
                    if (st.out_free) state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/msf_datapath.sv
// Datapath of the fuser: report and filled-mark memories, sum, constant dividers,
// grid snap, clamp, room registers and the output register.
// Depends on msf_pkg and msf_div.
module msf_datapath #(
    parameter int ROBOT_COUNT  = msf_pkg::DEF_ROBOT_COUNT,
    parameter int SOURCE_COUNT = msf_pkg::DEF_SOURCE_COUNT,
    parameter int GRID_PITCH   = msf_pkg::DEF_GRID_PITCH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [msf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               cfg_we,
    input  logic [msf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [msf_pkg::ROOM_W-1:0]         cfg_wdata,
    input  msf_pkg::ctrl_cmd_t                 cmd,
    output msf_pkg::dp_status_t                st,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [msf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [msf_pkg::STATUS_W-1:0]       m_tuser
);

    import msf_pkg::*;

    localparam int RW     = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;
    localparam int SW     = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int SLOTS  = ROBOT_COUNT * (1 << SW);
    localparam int CNT_W  = $clog2(SOURCE_COUNT + 1);
    localparam int SUM_W  = COORD_W + $clog2(SOURCE_COUNT);
    // 2 * mean + pitch stays below 2^14
    localparam int RND_W  = COORD_W + 2;
    localparam int PW     = $clog2(GRID_PITCH + 1);
    localparam int Q_W    = 13;
    localparam int SNAP_W = 13;
    localparam int CLP_W  = ROOM_W + 2;

    localparam logic [INDEX_W-1:0] ROBOT_LIM  = INDEX_W'(ROBOT_COUNT);
    localparam logic [INDEX_W-1:0] SOURCE_LIM = INDEX_W'(SOURCE_COUNT);
    localparam logic [PW-1:0]      PITCH_C    = PW'(GRID_PITCH);

    // captured request
    logic [INDEX_W-1:0] robot_reg;
    logic [INDEX_W-1:0] source_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    logic [ROOM_W-1:0]  room_w_reg;
    logic [ROOM_W-1:0]  room_h_reg;

    // report store: {y, x}, and filled marks as one row per robot
    logic [2*COORD_W-1:0]    coords_mem [SLOTS];
    logic [SOURCE_COUNT-1:0] filled_mem [ROBOT_COUNT];
    logic [ROBOT_COUNT-1:0]  row_valid_reg;
    logic [SOURCE_COUNT-1:0] filled_rd_reg;
    logic                    row_vld_rd_reg;
    logic [2*COORD_W-1:0]    coords_rd_reg;

    logic [RW-1:0]           robot_sel;
    logic [SW-1:0]           source_sel;
    logic [SOURCE_COUNT-1:0] row_mask;

    logic [CNT_W-1:0]   sum_cnt_reg;
    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;

    logic [COORD_W-1:0] mean_x_reg;
    logic [COORD_W-1:0] mean_y_reg;
    logic [Q_W-1:0]     q_x_reg;
    logic [Q_W-1:0]     q_y_reg;
    logic [SNAP_W-1:0]  snap_x_reg;
    logic [SNAP_W-1:0]  snap_y_reg;

    logic [SUM_W-1:0]   mean_dividend;
    logic [SUM_W-1:0]   mean_quot;
    logic               mean_start;
    logic               mean_done;
    logic [RND_W-1:0]   rnd_dividend;
    logic [RND_W-1:0]   rnd_quot;
    logic               rnd_start;
    logic               rnd_done;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;
    logic [COORD_W-1:0]     fused_x;
    logic [COORD_W-1:0]     fused_y;

    // clamp to [0, room - pitch], saturate at the coordinate range
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [SNAP_W-1:0] snap,
        input logic [ROOM_W-1:0] room
    );
        logic signed [CLP_W-1:0] upper;
        logic signed [CLP_W-1:0] val;
        upper = $signed({2'b00, room}) - $signed(CLP_W'(GRID_PITCH));
        val   = $signed(CLP_W'(snap));
        if (val > upper) val = upper;
        if (val < $signed(CLP_W'(0))) val = '0;
        if (val > $signed(CLP_W'(4095))) val = CLP_W'(4095);
        return val[COORD_W-1:0];
    endfunction

    assign robot_sel  = robot_reg[RW-1:0];
    assign source_sel = source_reg[SW-1:0];

    always_comb begin
        row_mask = (row_vld_rd_reg ? filled_rd_reg : '0)
                 | (SOURCE_COUNT'(1) << source_sel);
    end

    always_comb begin
        st.bad_index = (robot_reg >= ROBOT_LIM) || (source_reg >= SOURCE_LIM);
        st.row_full  = &row_mask;
        st.sum_done  = (sum_cnt_reg == CNT_W'(SOURCE_COUNT));
        st.div_done  = mean_done || rnd_done;
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            robot_reg  <= s_tdata[7:0];
            source_reg <= s_tdata[15:8];
            x_reg      <= s_tdata[27:16];
            y_reg      <= s_tdata[39:28];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_w_reg <= ROOM_RESET;
            room_h_reg <= ROOM_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ROOM_WIDTH:  room_w_reg <= cfg_wdata;
                REG_ROOM_HEIGHT: room_h_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // store the report and fetch the robot's filled row
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            coords_mem[{robot_sel, source_sel}] <= {y_reg, x_reg};
            filled_rd_reg  <= filled_mem[robot_sel];
            row_vld_rd_reg <= row_valid_reg[robot_sel];
        end
        if (cmd.check) begin
            filled_mem[robot_sel] <= st.row_full ? '0 : row_mask;
        end
        if (cmd.sum_run && (sum_cnt_reg < CNT_W'(SOURCE_COUNT))) begin
            coords_rd_reg <= coords_mem[{robot_sel, sum_cnt_reg[SW-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.check) begin
            row_valid_reg[robot_sel] <= 1'b1;
        end
    end

    // walk the row one slot a cycle; the slot read goes through coords_rd_reg, so the adds start at count one
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            sum_cnt_reg <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
        end else if (cmd.sum_run) begin
            sum_cnt_reg <= sum_cnt_reg + 1'b1;
            if (sum_cnt_reg != '0) begin
                sum_x_reg <= sum_x_reg + SUM_W'(coords_rd_reg[COORD_W-1:0]);
                sum_y_reg <= sum_y_reg + SUM_W'(coords_rd_reg[2*COORD_W-1:COORD_W]);
            end
        end
    end

    // q = (2 * mean + pitch) / (2 * pitch) gives half-up rounding
    always_comb begin
        mean_dividend = sum_y_reg;
        rnd_dividend  = RND_W'({mean_y_reg, 1'b0}) + RND_W'(GRID_PITCH);
        mean_start    = 1'b0;
        rnd_start     = 1'b0;
        case (cmd.div_op)
            OP_MEAN_X: begin
                mean_dividend = sum_x_reg;
                mean_start    = cmd.div_start;
            end
            OP_MEAN_Y: begin
                mean_start    = cmd.div_start;
            end
            OP_Q_X: begin
                rnd_dividend  = RND_W'({mean_x_reg, 1'b0}) + RND_W'(GRID_PITCH);
                rnd_start     = cmd.div_start;
            end
            default: begin
                rnd_start     = cmd.div_start;
            end
        endcase
    end

    msf_div #(
        .DIV_W   (SUM_W),
        .DIVISOR (SOURCE_COUNT)
    ) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mean_start),
        .dividend (mean_dividend),
        .done     (mean_done),
        .quot     (mean_quot)
    );

    msf_div #(
        .DIV_W   (RND_W),
        .DIVISOR (2 * GRID_PITCH)
    ) u_rnd_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rnd_start),
        .dividend (rnd_dividend),
        .done     (rnd_done),
        .quot     (rnd_quot)
    );

    always_ff @(posedge aclk) begin
        if (mean_done || rnd_done) begin
            case (cmd.div_op)
                OP_MEAN_X: mean_x_reg <= mean_quot[COORD_W-1:0];
                OP_MEAN_Y: mean_y_reg <= mean_quot[COORD_W-1:0];
                OP_Q_X:    q_x_reg    <= rnd_quot[Q_W-1:0];
                default:   q_y_reg    <= rnd_quot[Q_W-1:0];
            endcase
        end
        if (cmd.scale) begin
            snap_x_reg <= SNAP_W'(q_x_reg * PITCH_C);
            snap_y_reg <= SNAP_W'(q_y_reg * PITCH_C);
        end
    end

    always_comb begin
        if (cmd.emit_status == ST_FUSED) begin
            fused_x = clamp_coord(snap_x_reg, room_w_reg);
            fused_y = clamp_coord(snap_y_reg, room_h_reg);
        end else begin
            fused_x = '0;
            fused_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {fused_y, fused_x, robot_reg};
            m_tuser_reg <= cmd.emit_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hw/rtl/msf_checker.sv
// Port-level checks of the position fuser, bound to the top level.
// Depends on msf_pkg and multi_source_position_fuser_core.
module msf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [msf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [msf_pkg::STATUS_W-1:0]    m_tuser
);

    import msf_pkg::*;

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // one request in work at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // only a fused result carries coordinates
    a_zero_unfused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FUSED) |-> (m_tdata[31:8] == '0))
        else $error("non-fused result with nonzero coordinates");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind multi_source_position_fuser_core msf_checker u_msf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
